// File: design/nfcs_pkg.sv
// Shared types and constants of the NAND flash command sequencer.
// Depends on nothing; every other file of the block but nfcs_if imports it.
package nfcs_pkg;

	localparam int unsigned PAGES_PER_BLOCK_DEF = 64;
	localparam int unsigned ID_BYTES_DEF = 5;
	localparam int unsigned MAX_RESULTS = 8;
	localparam logic [12:0] MAX_BYTES = 13'd4096;

	// Request codes.
	localparam logic [2:0] REQ_RESET = 3'd0;
	localparam logic [2:0] REQ_READ_ID = 3'd1;
	localparam logic [2:0] REQ_PAGE_READ = 3'd2;
	localparam logic [2:0] REQ_PROGRAM = 3'd3;
	localparam logic [2:0] REQ_ERASE = 3'd4;
	localparam logic [2:0] REQ_PAYLOAD = 3'd5;
	localparam logic [2:0] REQ_SAMPLE = 3'd6;

	// Bus cycle kinds.
	localparam logic [2:0] KIND_CMD = 3'd0;
	localparam logic [2:0] KIND_ADDR = 3'd1;
	localparam logic [2:0] KIND_DWRITE = 3'd2;
	localparam logic [2:0] KIND_DREAD = 3'd3;
	localparam logic [2:0] KIND_DONE = 3'd4;

	// Completion status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_PROTECTED = 2'd2;
	localparam logic [1:0] ST_FAILED = 2'd3;

	// Flash command bytes.
	localparam logic [7:0] CMD_RESET = 8'hFF;
	localparam logic [7:0] CMD_READ_ID = 8'h90;
	localparam logic [7:0] CMD_READ1 = 8'h00;
	localparam logic [7:0] CMD_READ2 = 8'h30;
	localparam logic [7:0] CMD_PROG1 = 8'h80;
	localparam logic [7:0] CMD_PROG2 = 8'h10;
	localparam logic [7:0] CMD_ERASE1 = 8'h60;
	localparam logic [7:0] CMD_ERASE2 = 8'hD0;
	localparam logic [7:0] CMD_STATUS = 8'h70;

	// Configuration register indexes and reset values.
	localparam logic [1:0] CFG_READ_LIMIT = 2'd0;
	localparam logic [1:0] CFG_PROG_LIMIT = 2'd1;
	localparam logic [1:0] CFG_ERASE_LIMIT = 2'd2;
	localparam logic [15:0] READ_LIMIT_RST = 16'd200;
	localparam logic [15:0] PROG_LIMIT_RST = 16'd2000;
	localparam logic [15:0] ERASE_LIMIT_RST = 16'd4000;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic [1:0] status;
	} bus_res_t;

	// One burst of results caused by one accepted request.
	typedef struct packed {
		logic [3:0] count;
		bus_res_t [MAX_RESULTS-1:0] res;
	} burst_t;

endpackage

// File: design/nfcs_if.sv
// Handshake channels of the sequencer: the request channel and the result channel.
// Depends on nothing.
interface nfcs_req_if;
	logic valid;
	logic ready;
	logic [2:0] req_type;
	logic [23:0] target_addr;
	logic [11:0] col_offset;
	logic [12:0] byte_count;
	logic [7:0] payload_byte;
	logic ready_level;
	logic [7:0] flash_byte;

	modport source (output valid, req_type, target_addr, col_offset, byte_count,
		payload_byte, ready_level, flash_byte, input ready);
	modport sink (input valid, req_type, target_addr, col_offset, byte_count,
		payload_byte, ready_level, flash_byte, output ready);
endinterface

interface nfcs_res_if;
	logic valid;
	logic ready;
	logic [2:0] bus_kind;
	logic [7:0] bus_byte;
	logic [1:0] op_status;
	logic last;

	modport source (output valid, bus_kind, bus_byte, op_status, last, input ready);
	modport sink (input valid, bus_kind, bus_byte, op_status, last, output ready);
endinterface

// File: design/nfcs_front.sv
// Front end: holds the sequencer state and the wait limits, accepts requests and
// turns each into a burst of bus results. Depends on nfcs_pkg and nfcs_if.
module nfcs_front #(
	parameter int unsigned PAGES_PER_BLOCK = nfcs_pkg::PAGES_PER_BLOCK_DEF,
	parameter int unsigned ID_BYTES = nfcs_pkg::ID_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [15:0] cfg_data,
	nfcs_req_if.sink req,
	input logic q_full,
	output logic push,
	output nfcs_pkg::burst_t burst
);
	import nfcs_pkg::*;

	typedef enum logic [2:0] {PH_IDLE, PH_ID, PH_RWAIT, PH_RDATA, PH_PDATA, PH_PWAIT} phase_t;

	localparam logic [23:0] PPB = 24'(PAGES_PER_BLOCK);

	phase_t phase_q, phase_d;
	logic erase_q, erase_d;
	logic [15:0] wait_q, wait_d;
	logic [12:0] left_q, left_d;
	logic tout_q, tout_d;
	logic [15:0] rd_lim_q, pg_lim_q, er_lim_q;

	logic accept;
	logic [12:0] cnt, left_dec;
	logic [23:0] erase_row;
	logic [15:0] lim;
	logic [16:0] wait_inc;
	logic w_ready, w_tout;
	logic [1:0] st;

	assign req.ready = !q_full;
	assign accept = req.valid && req.ready;
	assign push = accept && (burst.count != 4'd0);

	assign cnt = (req.byte_count > MAX_BYTES) ? MAX_BYTES : req.byte_count;
	assign left_dec = (left_q != 13'd0) ? left_q - 13'd1 : 13'd0;
	assign erase_row = req.target_addr * PPB;
	assign lim = (phase_q == PH_RWAIT) ? rd_lim_q : (erase_q ? er_lim_q : pg_lim_q);

	// Wait step: a count already at the limit times out at once, otherwise the
	// sample counts, ready ends the wait, and a busy sample at the limit times out.
	assign wait_inc = {1'b0, wait_q} + 17'd1;
	assign w_tout = ({1'b0, wait_q} >= {1'b0, lim}) ||
		(!req.ready_level && (wait_inc >= {1'b0, lim}));
	assign w_ready = !w_tout && req.ready_level;

	always_comb begin
		phase_d = phase_q;
		erase_d = erase_q;
		wait_d = wait_q;
		left_d = left_q;
		tout_d = tout_q;
		burst = '0;
		st = ST_OK;
		case (req.req_type)
			REQ_RESET: begin
				burst.res[0] = '{KIND_CMD, CMD_RESET, ST_OK};
				burst.res[1] = '{KIND_DONE, 8'h00, ST_OK};
				burst.count = 4'd2;
				phase_d = PH_IDLE;
			end
			REQ_READ_ID, REQ_PAGE_READ, REQ_PROGRAM, REQ_ERASE: begin
				if (phase_q == PH_IDLE) begin
					wait_d = '0;
					tout_d = 1'b0;
					erase_d = 1'b0;
					case (req.req_type)
						REQ_READ_ID: begin
							burst.res[0] = '{KIND_CMD, CMD_READ_ID, ST_OK};
							burst.res[1] = '{KIND_ADDR, 8'h00, ST_OK};
							burst.count = 4'd2;
							left_d = 13'(ID_BYTES);
							phase_d = PH_ID;
						end
						REQ_ERASE: begin
							burst.res[0] = '{KIND_CMD, CMD_ERASE1, ST_OK};
							burst.res[1] = '{KIND_ADDR, erase_row[7:0], ST_OK};
							burst.res[2] = '{KIND_ADDR, erase_row[15:8], ST_OK};
							burst.res[3] = '{KIND_ADDR, erase_row[23:16], ST_OK};
							burst.res[4] = '{KIND_CMD, CMD_ERASE2, ST_OK};
							burst.count = 4'd5;
							erase_d = 1'b1;
							left_d = '0;
							phase_d = PH_PWAIT;
						end
						default: begin
							burst.res[0] = '{KIND_CMD,
								(req.req_type == REQ_PAGE_READ) ? CMD_READ1 : CMD_PROG1, ST_OK};
							burst.res[1] = '{KIND_ADDR, req.col_offset[7:0], ST_OK};
							burst.res[2] = '{KIND_ADDR, {4'h0, req.col_offset[11:8]}, ST_OK};
							burst.res[3] = '{KIND_ADDR, req.target_addr[7:0], ST_OK};
							burst.res[4] = '{KIND_ADDR, req.target_addr[15:8], ST_OK};
							burst.res[5] = '{KIND_ADDR, req.target_addr[23:16], ST_OK};
							left_d = cnt;
							if (req.req_type == REQ_PAGE_READ) begin
								burst.res[6] = '{KIND_CMD, CMD_READ2, ST_OK};
								burst.count = 4'd7;
								phase_d = PH_RWAIT;
							end else if (cnt == 13'd0) begin
								burst.res[6] = '{KIND_CMD, CMD_PROG2, ST_OK};
								burst.count = 4'd7;
								phase_d = PH_PWAIT;
							end else begin
								burst.count = 4'd6;
								phase_d = PH_PDATA;
							end
						end
					endcase
				end
			end
			REQ_PAYLOAD: begin
				if (phase_q == PH_PDATA) begin
					burst.res[0] = '{KIND_DWRITE, req.payload_byte, ST_OK};
					left_d = left_dec;
					if (left_dec == 13'd0) begin
						burst.res[1] = '{KIND_CMD, CMD_PROG2, ST_OK};
						burst.count = 4'd2;
						wait_d = '0;
						phase_d = PH_PWAIT;
					end else begin
						burst.count = 4'd1;
					end
				end
			end
			REQ_SAMPLE: begin
				case (phase_q)
					PH_ID, PH_RDATA: begin
						burst.res[0] = '{KIND_DREAD, req.flash_byte, ST_OK};
						left_d = left_dec;
						if (left_dec == 13'd0) begin
							burst.res[1] = '{KIND_DONE, 8'h00, tout_q ? ST_TIMEOUT : ST_OK};
							burst.count = 4'd2;
							phase_d = PH_IDLE;
						end else begin
							burst.count = 4'd1;
						end
					end
					PH_RWAIT: begin
						if (!w_tout) begin
							wait_d = wait_inc[15:0];
						end
						if (w_tout || w_ready) begin
							tout_d = w_tout;
							if (left_q == 13'd0) begin
								burst.res[0] = '{KIND_DONE, 8'h00, w_tout ? ST_TIMEOUT : ST_OK};
								burst.count = 4'd1;
								phase_d = PH_IDLE;
							end else begin
								phase_d = PH_RDATA;
							end
						end
					end
					PH_PWAIT: begin
						if (!w_tout) begin
							wait_d = wait_inc[15:0];
						end
						if (w_tout) begin
							burst.res[0] = '{KIND_DONE, 8'h00, ST_TIMEOUT};
							burst.count = 4'd1;
							phase_d = PH_IDLE;
						end else if (w_ready) begin
							if (!req.flash_byte[7]) begin
								st = ST_PROTECTED;
							end else if (req.flash_byte[0]) begin
								st = ST_FAILED;
							end
							burst.res[0] = '{KIND_CMD, CMD_STATUS, ST_OK};
							burst.res[1] = '{KIND_DREAD, req.flash_byte, ST_OK};
							burst.res[2] = '{KIND_DONE, 8'h00, st};
							burst.count = 4'd3;
							phase_d = PH_IDLE;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
		// Every completion returns the sequencer to its idle state.
		if (phase_d == PH_IDLE) begin
			erase_d = 1'b0;
			wait_d = '0;
			left_d = '0;
			tout_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			erase_q <= 1'b0;
			wait_q <= '0;
			left_q <= '0;
			tout_q <= 1'b0;
			rd_lim_q <= READ_LIMIT_RST;
			pg_lim_q <= PROG_LIMIT_RST;
			er_lim_q <= ERASE_LIMIT_RST;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				erase_q <= erase_d;
				wait_q <= wait_d;
				left_q <= left_d;
				tout_q <= tout_d;
			end
			if (cfg_we) begin
				case (cfg_idx)
					CFG_READ_LIMIT: rd_lim_q <= cfg_data;
					CFG_PROG_LIMIT: pg_lim_q <= cfg_data;
					CFG_ERASE_LIMIT: er_lim_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end
endmodule

// File: design/nfcs_queue.sv
// Two-entry queue of result bursts between the front end and the back end.
// Depends on nfcs_pkg.
module nfcs_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input nfcs_pkg::burst_t push_data,
	input logic pop,
	output nfcs_pkg::burst_t head,
	output logic full,
	output logic empty
);
	import nfcs_pkg::*;

	burst_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// File: design/nfcs_back.sv
// Back end: plays out the head burst of the queue one bus result per transfer
// and marks the final result of each burst. Depends on nfcs_pkg and nfcs_if.
module nfcs_back (
	input logic clk,
	input logic arst_n,
	input nfcs_pkg::burst_t head,
	input logic empty,
	output logic pop,
	nfcs_res_if.source res
);
	import nfcs_pkg::*;

	logic [2:0] idx_q;
	logic at_end;
	bus_res_t cur;

	assign cur = head.res[idx_q];
	assign at_end = ({1'b0, idx_q} == head.count - 4'd1);
	assign res.valid = !empty;
	assign res.bus_kind = cur.kind;
	assign res.bus_byte = cur.data;
	assign res.op_status = cur.status;
	assign res.last = at_end;
	assign pop = res.valid && res.ready && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (res.valid && res.ready) begin
			idx_q <= at_end ? 3'd0 : idx_q + 3'd1;
		end
	end
endmodule

// File: design/nand_flash_command_sequencer.sv
// Top level of the NAND flash command sequencer: front end, burst queue, back end.
// Depends on nfcs_pkg, nfcs_if, nfcs_front, nfcs_queue and nfcs_back.
//
//   Channel  Direction  Content
//   req      in         reset/ID/read/program/erase requests, payload bytes, bus samples
//   res      out        command, address, data and completion bus cycles
//   cfg      in         write-only wait limits (read, program, erase)
//
// The front end takes one request per cycle while the queue is not full and decides
// all of its results at once; the back end sends them one transfer per cycle while
// the result side is ready, so a request that causes k results takes k transfers.
// A two-entry burst queue sits between them: requests keep flowing while the
// result side stalls, and the request channel stalls only when both entries are full.
// Reset (arst_n low) returns the sequencer to idle, empties the queue and
// loads the wait limits with 200, 2000 and 4000.
module nand_flash_command_sequencer #(
	parameter int unsigned PAGES_PER_BLOCK = nfcs_pkg::PAGES_PER_BLOCK_DEF,
	parameter int unsigned ID_BYTES = nfcs_pkg::ID_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [15:0] cfg_data,
	nfcs_req_if.sink req,
	nfcs_res_if.source res
);
	import nfcs_pkg::*;

	burst_t burst, head;
	logic push, pop, q_full, q_empty;

	// Request side: state, limits and burst building.
	nfcs_front #(
		.PAGES_PER_BLOCK(PAGES_PER_BLOCK),
		.ID_BYTES(ID_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.req(req),
		.q_full(q_full),
		.push(push),
		.burst(burst)
	);

	// Decoupling queue; only requests that cause results occupy an entry.
	nfcs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(burst),
		.pop(pop),
		.head(head),
		.full(q_full),
		.empty(q_empty)
	);

	// Result side: serializes each burst onto the result channel.
	nfcs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(q_empty),
		.pop(pop),
		.res(res)
	);

	// A burst is never written into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("burst pushed into a full queue");

	// Every queued burst carries at least one result.
	a_burst_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (burst.count != 4'd0))
		else $error("empty burst queued");

	// A pop happens only on the final transfer of a burst.
	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (res.valid && res.ready && res.last))
		else $error("burst retired before its final result");
endmodule
